// ----- hdl/cga_pkg.sv -----
// Package for the single-qubit Clifford group ALU: operator and stage types,
// command and axis codes, and the fixed lookup tables of the normal form.
// Depends on nothing; used by cga_decode and clifford_group_alu.
package cga_pkg;

    // One operator in the normal form E^e X^x S^s w^w.
    typedef struct packed {
        logic [1:0] e;
        logic       x;
        logic [1:0] s;
        logic [2:0] w;
    } t_cl;

    typedef enum logic [1:0] {
        CMD_MUL   = 2'd0,
        CMD_INV   = 2'd1,
        CMD_TCONJ = 2'd2,
        CMD_COSET = 2'd3
    } t_cmd;

    localparam logic [1:0] AXIS_I  = 2'd0;
    localparam logic [1:0] AXIS_H  = 2'd1;
    localparam logic [1:0] AXIS_SH = 2'd2;

    // Entry of the T-conjugation table.
    typedef struct packed {
        logic [1:0] axis;
        logic [1:0] s;
        logic [2:0] w;
    } t_tconj;

    // Contents of the first pipeline register.
    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] pe;
        logic [2:0] pw;
        logic       qx;
        logic [1:0] qs;
        logic [2:0] qw;
        t_cl        t3;
        t_cl        lut;
        logic [1:0] ls;
        logic [2:0] lw;
        logic [1:0] axis;
    } t_s1;

    function automatic t_cl cl_mk(input logic [1:0] e, input logic x,
                                  input logic [1:0] s, input logic [2:0] w);
        t_cl c;
        c.e = e;
        c.x = x;
        c.s = s;
        c.w = w;
        return c;
    endfunction

    // Reduces a two-bit exponent of E modulo three; a code of three acts as zero.
    function automatic logic [1:0] e_mod3(input logic [1:0] e);
        return (e == 2'd3) ? 2'd0 : e;
    endfunction

    function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= 3'd3) begin
            sum = sum - 3'd3;
        end
        return sum[1:0];
    endfunction

    // Moving E^k past X^x S^s.
    function automatic t_cl pass_e(input logic x, input logic [1:0] s, input logic [1:0] k);
        t_cl r;
        case ({x, s, k})
            5'b0_00_00: r = cl_mk(2'd0, 1'b0, 2'd0, 3'd0);
            5'b0_00_01: r = cl_mk(2'd1, 1'b0, 2'd0, 3'd0);
            5'b0_00_10: r = cl_mk(2'd2, 1'b0, 2'd0, 3'd0);
            5'b0_01_00: r = cl_mk(2'd0, 1'b0, 2'd1, 3'd0);
            5'b0_01_01: r = cl_mk(2'd2, 1'b0, 2'd3, 3'd6);
            5'b0_01_10: r = cl_mk(2'd1, 1'b1, 2'd3, 3'd4);
            5'b0_10_00: r = cl_mk(2'd0, 1'b0, 2'd2, 3'd0);
            5'b0_10_01: r = cl_mk(2'd1, 1'b1, 2'd2, 3'd2);
            5'b0_10_10: r = cl_mk(2'd2, 1'b1, 2'd0, 3'd0);
            5'b0_11_00: r = cl_mk(2'd0, 1'b0, 2'd3, 3'd0);
            5'b0_11_01: r = cl_mk(2'd2, 1'b1, 2'd3, 3'd6);
            5'b0_11_10: r = cl_mk(2'd1, 1'b0, 2'd1, 3'd2);
            5'b1_00_00: r = cl_mk(2'd0, 1'b1, 2'd0, 3'd0);
            5'b1_00_01: r = cl_mk(2'd1, 1'b0, 2'd2, 3'd0);
            5'b1_00_10: r = cl_mk(2'd2, 1'b1, 2'd2, 3'd2);
            5'b1_01_00: r = cl_mk(2'd0, 1'b1, 2'd1, 3'd0);
            5'b1_01_01: r = cl_mk(2'd2, 1'b1, 2'd1, 3'd0);
            5'b1_01_10: r = cl_mk(2'd1, 1'b1, 2'd1, 3'd0);
            5'b1_10_00: r = cl_mk(2'd0, 1'b1, 2'd2, 3'd0);
            5'b1_10_01: r = cl_mk(2'd1, 1'b1, 2'd0, 3'd6);
            5'b1_10_10: r = cl_mk(2'd2, 1'b0, 2'd2, 3'd6);
            5'b1_11_00: r = cl_mk(2'd0, 1'b1, 2'd3, 3'd0);
            5'b1_11_01: r = cl_mk(2'd2, 1'b0, 2'd1, 3'd4);
            5'b1_11_10: r = cl_mk(2'd1, 1'b0, 2'd3, 3'd2);
            default:    r = cl_mk(2'd0, 1'b0, 2'd0, 3'd0);
        endcase
        return r;
    endfunction

    // Moving X^x past S^s; only the s and w fields of the result are meaningful.
    function automatic t_cl pass_x(input logic [1:0] s, input logic x);
        t_cl r;
        case ({s, x})
            3'b00_0: r = cl_mk(2'd0, 1'b0, 2'd0, 3'd0);
            3'b00_1: r = cl_mk(2'd0, 1'b0, 2'd0, 3'd0);
            3'b01_0: r = cl_mk(2'd0, 1'b0, 2'd1, 3'd0);
            3'b01_1: r = cl_mk(2'd0, 1'b0, 2'd3, 3'd2);
            3'b10_0: r = cl_mk(2'd0, 1'b0, 2'd2, 3'd0);
            3'b10_1: r = cl_mk(2'd0, 1'b0, 2'd2, 3'd4);
            3'b11_0: r = cl_mk(2'd0, 1'b0, 2'd3, 3'd0);
            3'b11_1: r = cl_mk(2'd0, 1'b0, 2'd1, 3'd6);
            default: r = cl_mk(2'd0, 1'b0, 2'd0, 3'd0);
        endcase
        return r;
    endfunction

    // Inverse of E^e X^x S^s, phase excluded.
    function automatic t_cl inv_lut(input logic [1:0] e, input logic x, input logic [1:0] s);
        t_cl r;
        case ({e, x, s})
            5'b00_0_00: r = cl_mk(2'd0, 1'b0, 2'd0, 3'd0);
            5'b00_0_01: r = cl_mk(2'd0, 1'b0, 2'd3, 3'd0);
            5'b00_0_10: r = cl_mk(2'd0, 1'b0, 2'd2, 3'd0);
            5'b00_0_11: r = cl_mk(2'd0, 1'b0, 2'd1, 3'd0);
            5'b00_1_00: r = cl_mk(2'd0, 1'b1, 2'd0, 3'd0);
            5'b00_1_01: r = cl_mk(2'd0, 1'b1, 2'd1, 3'd6);
            5'b00_1_10: r = cl_mk(2'd0, 1'b1, 2'd2, 3'd4);
            5'b00_1_11: r = cl_mk(2'd0, 1'b1, 2'd3, 3'd2);
            5'b01_0_00: r = cl_mk(2'd2, 1'b0, 2'd0, 3'd0);
            5'b01_0_01: r = cl_mk(2'd1, 1'b0, 2'd1, 3'd2);
            5'b01_0_10: r = cl_mk(2'd2, 1'b1, 2'd0, 3'd0);
            5'b01_0_11: r = cl_mk(2'd1, 1'b1, 2'd3, 3'd4);
            5'b01_1_00: r = cl_mk(2'd2, 1'b1, 2'd2, 3'd2);
            5'b01_1_01: r = cl_mk(2'd1, 1'b1, 2'd1, 3'd6);
            5'b01_1_10: r = cl_mk(2'd2, 1'b0, 2'd2, 3'd2);
            5'b01_1_11: r = cl_mk(2'd1, 1'b0, 2'd3, 3'd4);
            5'b10_0_00: r = cl_mk(2'd1, 1'b0, 2'd0, 3'd0);
            5'b10_0_01: r = cl_mk(2'd2, 1'b1, 2'd3, 3'd6);
            5'b10_0_10: r = cl_mk(2'd1, 1'b1, 2'd2, 3'd2);
            5'b10_0_11: r = cl_mk(2'd2, 1'b0, 2'd3, 3'd6);
            5'b10_1_00: r = cl_mk(2'd1, 1'b0, 2'd2, 3'd0);
            5'b10_1_01: r = cl_mk(2'd2, 1'b1, 2'd1, 3'd6);
            5'b10_1_10: r = cl_mk(2'd1, 1'b1, 2'd0, 3'd2);
            5'b10_1_11: r = cl_mk(2'd2, 1'b0, 2'd1, 3'd6);
            default:    r = cl_mk(2'd0, 1'b0, 2'd0, 3'd0);
        endcase
        return r;
    endfunction

    // T conjugation of E^e X^x.
    function automatic t_tconj tconj_lut(input logic [1:0] e, input logic x);
        t_tconj r;
        case ({e, x})
            3'b00_0: r = '{axis: AXIS_I,  s: 2'd0, w: 3'd0};
            3'b00_1: r = '{axis: AXIS_I,  s: 2'd1, w: 3'd7};
            3'b01_0: r = '{axis: AXIS_H,  s: 2'd3, w: 3'd3};
            3'b01_1: r = '{axis: AXIS_H,  s: 2'd2, w: 3'd0};
            3'b10_0: r = '{axis: AXIS_SH, s: 2'd0, w: 3'd5};
            3'b10_1: r = '{axis: AXIS_SH, s: 2'd1, w: 3'd4};
            default: r = '{axis: AXIS_I,  s: 2'd0, w: 3'd0};
        endcase
        return r;
    endfunction

    // Left factor that strips the coset representative: identity, inv(H) or inv(SH).
    function automatic t_cl coset_rep(input logic [1:0] e);
        t_cl r;
        case (e)
            2'd1:    r = cl_mk(2'd1, 1'b0, 2'd1, 3'd5);
            2'd2:    r = cl_mk(2'd1, 1'b0, 2'd0, 3'd5);
            default: r = cl_mk(2'd0, 1'b0, 2'd0, 3'd0);
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/cga_decode.sv -----
// First pipeline stage logic: reduces the operands, picks the multiplier
// operands for each command and performs the first level of table lookups.
// Depends on cga_pkg.
module cga_decode (
    input  cga_pkg::t_cmd i_cmd,
    input  cga_pkg::t_cl  i_lhs,
    input  cga_pkg::t_cl  i_rhs,
    output cga_pkg::t_s1  o_s1
);
    import cga_pkg::*;

    t_cl    lhs_red;
    t_cl    rhs_red;
    t_cl    op_p;
    t_cl    op_q;
    t_cl    inv_e;
    t_tconj tc_e;

    always_comb begin
        lhs_red   = i_lhs;
        lhs_red.e = e_mod3(i_lhs.e);
        rhs_red   = i_rhs;
        rhs_red.e = e_mod3(i_rhs.e);

        // A coset decomposition is a multiplication by a fixed representative inverse.
        if (i_cmd == CMD_COSET) begin
            op_p = coset_rep(lhs_red.e);
            op_q = lhs_red;
        end else begin
            op_p = lhs_red;
            op_q = rhs_red;
        end

        inv_e = inv_lut(lhs_red.e, lhs_red.x, lhs_red.s);
        tc_e  = tconj_lut(lhs_red.e, lhs_red.x);

        o_s1.cmd = i_cmd;
        o_s1.pe  = op_p.e;
        o_s1.pw  = op_p.w;
        o_s1.qx  = op_q.x;
        o_s1.qs  = op_q.s;
        o_s1.qw  = op_q.w;
        o_s1.t3  = pass_e(op_p.x, op_p.s, op_q.e);
        o_s1.ls  = lhs_red.s;
        o_s1.lw  = lhs_red.w;

        case (i_cmd)
            CMD_TCONJ: begin
                o_s1.lut  = cl_mk(2'd0, lhs_red.x, tc_e.s, tc_e.w);
                o_s1.axis = tc_e.axis;
            end
            CMD_COSET: begin
                o_s1.lut  = inv_e;
                o_s1.axis = lhs_red.e;
            end
            CMD_MUL, CMD_INV: begin
                o_s1.lut  = inv_e;
                o_s1.axis = AXIS_I;
            end
            default: begin
                o_s1.lut  = inv_e;
                o_s1.axis = AXIS_I;
            end
        endcase
    end

endmodule

// ----- hdl/clifford_group_alu.sv -----
// Single-qubit Clifford group ALU (top level), built on cga_pkg and cga_decode.
// Takes one transaction per clock cycle when the output side is not stalled and
// presents exactly one result per transaction. There are three register stages:
// operand decode with the first table lookup, the second lookup with the
// exponent sums, and the output register that finishes the phase sum.
// Back-pressure stalls the stages that are full; an empty stage still takes a
// new transaction.
module clifford_group_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // lhs_e[1:0], lhs_x[2], lhs_s[4:3], lhs_w[7:5],
    // rhs_e[9:8], rhs_x[10], rhs_s[12:11], rhs_w[15:13]
    input  logic [15:0] i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // res_e[1:0], res_x[2], res_s[4:3], res_w[7:5]
    output logic [7:0]  o_m_axis_tdata,
    // axis[1:0]
    output logic [1:0]  o_m_axis_tuser
);
    import cga_pkg::*;

    t_cl        lhs_in;
    t_cl        rhs_in;
    t_s1        n_s1;
    t_s1        r_s1;
    logic       r_v1;
    logic       r_v2;
    logic       r_v3;
    logic       rdy1;
    logic       rdy2;
    logic       rdy3;

    t_cl        t2;
    t_cl        n_s2;
    logic [2:0] n_wb;
    logic [1:0] n_ax2;
    t_cl        r_s2;
    logic [2:0] r_wb;
    logic [1:0] r_ax2;

    logic [7:0] r_out;
    logic [1:0] r_axis;

    assign lhs_in = cl_mk(i_s_axis_tdata[1:0], i_s_axis_tdata[2],
                          i_s_axis_tdata[4:3], i_s_axis_tdata[7:5]);
    assign rhs_in = cl_mk(i_s_axis_tdata[9:8], i_s_axis_tdata[10],
                          i_s_axis_tdata[12:11], i_s_axis_tdata[15:13]);

    cga_decode u_decode (
        .i_cmd (t_cmd'(i_s_axis_tuser)),
        .i_lhs (lhs_in),
        .i_rhs (rhs_in),
        .o_s1  (n_s1)
    );

    // A stage may load when it is empty or when its content moves on.
    assign rdy3 = !r_v3 || i_m_axis_tready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1 <= n_s1;
        end
    end

    // Second stage: finish the multiply chain or adjust the single-table results.
    // The phase is kept as two addends so that the last stage does one short add.
    always_comb begin
        t2    = pass_x(r_s1.t3.s, r_s1.qx);
        n_ax2 = r_s1.axis;
        case (r_s1.cmd)
            CMD_MUL, CMD_COSET: begin
                n_s2.e = (r_s1.cmd == CMD_COSET) ? 2'd0 : add_mod3(r_s1.pe, r_s1.t3.e);
                n_s2.x = r_s1.t3.x ^ r_s1.qx;
                n_s2.s = t2.s + r_s1.qs;
                n_s2.w = t2.w + r_s1.t3.w;
                n_wb   = r_s1.pw + r_s1.qw;
            end
            CMD_INV: begin
                n_s2   = r_s1.lut;
                n_wb   = 3'd0 - r_s1.lw;
            end
            CMD_TCONJ: begin
                n_s2.e = 2'd0;
                n_s2.x = r_s1.lut.x;
                n_s2.s = r_s1.lut.s + r_s1.ls;
                n_s2.w = r_s1.lut.w;
                n_wb   = r_s1.lw;
            end
            default: begin
                n_s2   = cl_mk(2'd0, 1'b0, 2'd0, 3'd0);
                n_wb   = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2  <= n_s2;
            r_wb  <= n_wb;
            r_ax2 <= n_ax2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_out  <= {r_s2.w + r_wb, r_s2.s, r_s2.x, r_s2.e};
            r_axis <= r_ax2;
        end
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = r_out;
    assign o_m_axis_tuser  = r_axis;

`ifndef ASSERT_OFF
    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && rdy2) |=> r_v2)
        else $error("stage two lost a transaction from stage one");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while the pipeline is full and stalled");

    a_e_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] != 2'd3))
        else $error("result exponent of E out of range");

    a_axis_e_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != AXIS_I)) |-> (o_m_axis_tdata[1:0] == 2'd0))
        else $error("non-trivial axis with a non-zero E exponent");
`endif

endmodule
